### src/gmdfs_pkg.sv
// Shared types and constants of the grid maze depth-first solver.
`timescale 1ns / 1ps

package gmdfs_pkg;

    localparam int COORD_W = 3;
    localparam int CODE_W  = 3;
    localparam int DIR_W   = 3;

    // Cell contents.
    localparam logic [CODE_W-1:0] CODE_WALL   = 3'd0;
    localparam logic [CODE_W-1:0] CODE_OPEN   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_START  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_FINISH = 3'd3;
    localparam logic [CODE_W-1:0] CODE_PATH   = 3'd4;

    // Input beat kinds.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    // Search directions, tried in this order; DIR_DONE means all four failed.
    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;
    localparam logic [DIR_W-1:0] DIR_DONE = 3'd4;

    typedef enum logic [1:0] {
        RD_CNT,
        RD_CNT_NEXT,
        RD_START,
        RD_NB
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_IN,
        WR_POS,
        WR_NB,
        WR_START
    } wr_sel_t;

    // One saved search frame: the parent cell and the direction taken from it.
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [1:0]         dir;
    } stack_entry_t;

    typedef struct packed {
        rd_sel_t             rd_sel;
        logic                grid_we;
        wr_sel_t             wr_sel;
        logic [CODE_W-1:0]   wcode;
        logic                cnt_clear;
        logic                cnt_inc;
        logic                start_clear;
        logic                start_capture;
        logic                pos_load_start;
        logic                dir_inc;
        logic                push;
        logic                pop_rd;
        logic                pop_load;
        logic                sp_clear;
        logic                out_load;
        logic                out_solved;
    } dp_cmd_t;

    typedef struct packed {
        logic [CODE_W-1:0] rd_code;
        logic              in_cmd;
        logic              in_ok;
        logic              dir_done;
        logic              nb_ok;
        logic              sp_zero;
        logic              cnt_last;
        logic              out_free;
    } dp_status_t;

endpackage

### src/gmdfs_datapath.sv
// Datapath of the maze solver: grid memory, search stack, position and output registers.
`timescale 1ns / 1ps

module gmdfs_datapath #(
    parameter int GRID_SIDE = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [15:0]           s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,
    output logic                  m_tlast,
    input  gmdfs_pkg::dp_cmd_t    cmd,
    output gmdfs_pkg::dp_status_t status
);
    import gmdfs_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int SPW   = $clog2(CELLS + 1);
    localparam logic [COORD_W:0]   SIDE = (COORD_W + 1)'(GRID_SIDE);
    localparam logic [COORD_W-1:0] LAST = COORD_W'(GRID_SIDE - 1);

    function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                input logic [COORD_W-1:0] c);
        return AW'(int'(r) * GRID_SIDE + int'(c));
    endfunction

    logic [CODE_W-1:0]  grid_mem [CELLS];
    logic [CELLS-1:0]   written_reg;
    logic [CODE_W-1:0]  grid_rd_reg;
    logic               rd_valid_reg;
    stack_entry_t       stack_mem [CELLS];
    stack_entry_t       stack_rd_reg;

    logic [COORD_W-1:0] cnt_row_reg, cnt_row_next, cnt_col_reg, cnt_col_next;
    logic [COORD_W-1:0] start_row_reg, start_row_next, start_col_reg, start_col_next;
    logic [COORD_W-1:0] pos_row_reg, pos_row_next, pos_col_reg, pos_col_next;
    logic [DIR_W-1:0]   dir_reg, dir_next;
    logic [SPW-1:0]     sp_reg, sp_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_solved_reg, out_solved_next;
    logic [COORD_W-1:0] out_row_reg, out_row_next, out_col_reg, out_col_next;
    logic [CODE_W-1:0]  out_code_reg, out_code_next;
    logic               out_last_reg, out_last_next;

    logic [COORD_W-1:0] in_row, in_col, in_code;
    logic [COORD_W-1:0] inc_row, inc_col;
    logic [COORD_W-1:0] nb_row, nb_col;
    logic               nb_ok, cnt_last;
    logic [CODE_W-1:0]  rd_code;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [CODE_W-1:0]  wr_data;
    logic [SPW-1:0]     sp_dec;
    stack_entry_t       push_entry;

    assign in_row  = s_tdata[2:0];
    assign in_col  = s_tdata[5:3];
    assign in_code = s_tdata[8:6];

    assign rd_code  = rd_valid_reg ? grid_rd_reg : CODE_WALL;
    assign cnt_last = (cnt_row_reg == LAST) && (cnt_col_reg == LAST);
    assign inc_row  = (cnt_col_reg == LAST) ? cnt_row_reg + 3'd1 : cnt_row_reg;
    assign inc_col  = (cnt_col_reg == LAST) ? '0 : cnt_col_reg + 3'd1;
    assign sp_dec   = sp_reg - SPW'(1);

    always_comb begin
        nb_row = pos_row_reg;
        nb_col = pos_col_reg;
        nb_ok  = 1'b0;
        case (dir_reg[1:0])
            DIR_RIGHT: begin
                nb_ok  = ({1'b0, pos_col_reg} + 4'd1) < SIDE;
                nb_col = pos_col_reg + 3'd1;
            end
            DIR_DOWN: begin
                nb_ok  = ({1'b0, pos_row_reg} + 4'd1) < SIDE;
                nb_row = pos_row_reg + 3'd1;
            end
            DIR_UP: begin
                nb_ok  = pos_row_reg != '0;
                nb_row = pos_row_reg - 3'd1;
            end
            default: begin
                nb_ok  = pos_col_reg != '0;
                nb_col = pos_col_reg - 3'd1;
            end
        endcase
    end

    always_comb begin
        case (cmd.rd_sel)
            RD_CNT:      rd_addr = cell_addr(cnt_row_reg, cnt_col_reg);
            RD_CNT_NEXT: rd_addr = cell_addr(inc_row, inc_col);
            RD_START:    rd_addr = cell_addr(start_row_reg, start_col_reg);
            RD_NB:       rd_addr = cell_addr(nb_row, nb_col);
            default:     rd_addr = cell_addr(cnt_row_reg, cnt_col_reg);
        endcase
        wr_data = cmd.wcode;
        case (cmd.wr_sel)
            WR_IN: begin
                wr_addr = cell_addr(in_row, in_col);
                wr_data = in_code;
            end
            WR_POS:   wr_addr = cell_addr(pos_row_reg, pos_col_reg);
            WR_NB:    wr_addr = cell_addr(nb_row, nb_col);
            WR_START: wr_addr = cell_addr(start_row_reg, start_col_reg);
            default:  wr_addr = cell_addr(pos_row_reg, pos_col_reg);
        endcase
    end

    // Grid storage; a cell never written reads as wall through its written bit.
    always_ff @(posedge aclk) begin
        if (cmd.grid_we) begin
            grid_mem[wr_addr] <= wr_data;
        end
        grid_rd_reg <= grid_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (cmd.grid_we) begin
                written_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= written_reg[rd_addr];
        end
    end

    assign push_entry = '{row: pos_row_reg, col: pos_col_reg, dir: dir_reg[1:0]};

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            stack_mem[sp_reg[AW-1:0]] <= push_entry;
        end
        if (cmd.pop_rd) begin
            stack_rd_reg <= stack_mem[sp_dec[AW-1:0]];
        end
    end

    always_comb begin
        cnt_row_next    = cnt_row_reg;
        cnt_col_next    = cnt_col_reg;
        start_row_next  = start_row_reg;
        start_col_next  = start_col_reg;
        pos_row_next    = pos_row_reg;
        pos_col_next    = pos_col_reg;
        dir_next        = dir_reg;
        sp_next         = sp_reg;
        out_valid_next  = out_valid_reg;
        out_solved_next = out_solved_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_code_next   = out_code_reg;
        out_last_next   = out_last_reg;

        if (cmd.cnt_clear) begin
            cnt_row_next = '0;
            cnt_col_next = '0;
        end else if (cmd.cnt_inc) begin
            cnt_row_next = inc_row;
            cnt_col_next = inc_col;
        end

        if (cmd.start_clear) begin
            start_row_next = '0;
            start_col_next = '0;
        end else if (cmd.start_capture && rd_code == CODE_START) begin
            start_row_next = cnt_row_reg;
            start_col_next = cnt_col_reg;
        end

        if (cmd.pos_load_start) begin
            pos_row_next = start_row_reg;
            pos_col_next = start_col_reg;
            dir_next     = '0;
        end else if (cmd.push) begin
            pos_row_next = nb_row;
            pos_col_next = nb_col;
            dir_next     = '0;
        end else if (cmd.pop_load) begin
            pos_row_next = stack_rd_reg.row;
            pos_col_next = stack_rd_reg.col;
            dir_next     = {1'b0, stack_rd_reg.dir} + 3'd1;
        end else if (cmd.dir_inc) begin
            dir_next = dir_reg + 3'd1;
        end

        if (cmd.sp_clear) begin
            sp_next = '0;
        end else if (cmd.push) begin
            sp_next = sp_reg + SPW'(1);
        end else if (cmd.pop_rd) begin
            sp_next = sp_dec;
        end

        if (cmd.out_load) begin
            out_valid_next  = 1'b1;
            out_solved_next = cmd.out_solved;
            out_row_next    = cmd.out_solved ? cnt_row_reg : '0;
            out_col_next    = cmd.out_solved ? cnt_col_reg : '0;
            out_code_next   = cmd.out_solved ? rd_code : '0;
            out_last_next   = cmd.out_solved ? cnt_last : 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_row_reg <= '0;
            start_col_reg <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            start_row_reg <= start_row_next;
            start_col_reg <= start_col_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
        cnt_row_reg    <= cnt_row_next;
        cnt_col_reg    <= cnt_col_next;
        pos_row_reg    <= pos_row_next;
        pos_col_reg    <= pos_col_next;
        dir_reg        <= dir_next;
        out_solved_reg <= out_solved_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_code_reg   <= out_code_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_code_reg, out_col_reg, out_row_reg, out_solved_reg};
    assign m_tlast  = out_last_reg;

    assign status.rd_code  = rd_code;
    assign status.in_cmd   = s_tuser;
    assign status.in_ok    = ({1'b0, in_row} < SIDE) && ({1'b0, in_col} < SIDE)
                             && (in_code <= CODE_PATH);
    assign status.dir_done = dir_reg == DIR_DONE;
    assign status.nb_ok    = nb_ok;
    assign status.sp_zero  = sp_reg == '0;
    assign status.cnt_last = cnt_last;
    assign status.out_free = !out_valid_reg || m_tready;

endmodule

### src/gmdfs_ctrl.sv
// Controller of the maze solver: sequences loading, start scan, search and grid emission.
`timescale 1ns / 1ps

module gmdfs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  gmdfs_pkg::dp_status_t status,
    output gmdfs_pkg::dp_cmd_t    cmd
);
    import gmdfs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_PRE,
        ST_SCAN,
        ST_START_RD,
        ST_START_CHK,
        ST_TRY,
        ST_TRY_CHK,
        ST_BACK,
        ST_POP,
        ST_FAIL,
        ST_SUCCESS,
        ST_EMIT_PRE,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = state_reg == ST_IDLE;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_CNT;
        cmd.wr_sel = WR_POS;
        cmd.wcode  = CODE_PATH;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (status.in_cmd == CMD_WRITE) begin
                        cmd.wr_sel  = WR_IN;
                        cmd.grid_we = status.in_ok;
                    end else begin
                        cmd.cnt_clear   = 1'b1;
                        cmd.start_clear = 1'b1;
                        state_next      = ST_SCAN_PRE;
                    end
                end
            end
            ST_SCAN_PRE: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.start_capture = 1'b1;
                if (status.cnt_last) begin
                    state_next = ST_START_RD;
                end else begin
                    cmd.cnt_inc = 1'b1;
                    cmd.rd_sel  = RD_CNT_NEXT;
                end
            end
            ST_START_RD: begin
                cmd.rd_sel         = RD_START;
                cmd.pos_load_start = 1'b1;
                cmd.sp_clear       = 1'b1;
                state_next         = ST_START_CHK;
            end
            ST_START_CHK: begin
                if (status.rd_code == CODE_FINISH) begin
                    state_next = ST_SUCCESS;
                end else if (status.rd_code inside {CODE_WALL, CODE_PATH}) begin
                    state_next = ST_FAIL;
                end else begin
                    cmd.grid_we = 1'b1;
                    state_next  = ST_TRY;
                end
            end
            ST_TRY: begin
                if (status.dir_done) begin
                    state_next = ST_BACK;
                end else if (!status.nb_ok) begin
                    cmd.dir_inc = 1'b1;
                end else begin
                    cmd.rd_sel = RD_NB;
                    state_next = ST_TRY_CHK;
                end
            end
            ST_TRY_CHK: begin
                if (status.rd_code == CODE_FINISH) begin
                    state_next = ST_SUCCESS;
                end else if (status.rd_code inside {CODE_WALL, CODE_PATH}) begin
                    cmd.dir_inc = 1'b1;
                    state_next  = ST_TRY;
                end else begin
                    cmd.grid_we = 1'b1;
                    cmd.wr_sel  = WR_NB;
                    cmd.push    = 1'b1;
                    state_next  = ST_TRY;
                end
            end
            ST_BACK: begin
                cmd.grid_we = 1'b1;
                cmd.wcode   = CODE_OPEN;
                if (status.sp_zero) begin
                    state_next = ST_FAIL;
                end else begin
                    cmd.pop_rd = 1'b1;
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                cmd.pop_load = 1'b1;
                state_next   = ST_TRY;
            end
            ST_FAIL: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.sp_clear = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SUCCESS: begin
                cmd.grid_we   = 1'b1;
                cmd.wr_sel    = WR_START;
                cmd.wcode     = CODE_START;
                cmd.sp_clear  = 1'b1;
                cmd.cnt_clear = 1'b1;
                state_next    = ST_EMIT_PRE;
            end
            ST_EMIT_PRE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_solved = 1'b1;
                    if (status.cnt_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.cnt_inc = 1'b1;
                        cmd.rd_sel  = RD_CNT_NEXT;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### src/grid_maze_depth_first_solver_unit.sv
// Top level of the grid maze depth-first solver.
`timescale 1ns / 1ps

// The block holds a square maze of GRID_SIDE x GRID_SIDE cells. Input beats with
// s_tuser low write one cell (wall, open, start, finish or path); a write with a
// row or column outside the grid or a code above path is dropped. An input beat
// with s_tuser high starts a solve: the grid is scanned for the last start cell in
// row-major order (row 0, column 0 if none), then a depth-first search walks from
// it, trying right, down, up and left, marking cells it enters as path and putting
// dead ends back to open. On success the start cell is restored and the whole grid
// goes out row-major, one beat per cell, tlast on the final cell. On failure one
// beat goes out with solved and all fields zero and tlast high. The marks stay in
// the grid for the next solve. Timing: a cell write leaves the input open, and the next
// beat is taken in the following cycle. A solve first scans every cell for the
// start cell, then reads and checks the start cell. The search then reads the
// grid for every neighbor probed, skips a neighbor outside the grid without a
// read, and on every backtrack reopens the cell and pops the stack, its pace set
// by the single read port of the grid memory. A failure then loads its beat; a
// success restores the start cell, after which emission runs at one cell per
// cycle while m_tready is high. The input side stays stalled for the whole solve
// until the last result beat has been loaded into the output register.

module grid_maze_depth_first_solver_unit #(
    parameter int GRID_SIDE = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [2:0] cell_row, [5:3] cell_col, [8:6] cell_code, zero fill
    input  logic        s_tuser,  // [0] cmd: 0 write one cell, 1 solve
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // [0] solved, [3:1] out_row, [6:4] out_col,
                                  // [9:7] out_code, zero fill
    output logic        m_tlast   // last
);
    import gmdfs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller only sequences; all data storage lives in the datapath.
    gmdfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gmdfs_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

`ifndef SYNTHESIS
    // While new beats are taken the search stack must be empty.
    a_idle_stack_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> status.sp_zero)
        else $error("search stack not empty while input is open");

    // A failure result is always a single beat carrying tlast.
    a_fail_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> m_tlast)
        else $error("failure beat without tlast");

    // The final beat of a grid dump belongs to the bottom right cell.
    a_last_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0] && m_tlast) |->
            (m_tdata[3:1] == 3'(GRID_SIDE - 1)) && (m_tdata[6:4] == 3'(GRID_SIDE - 1)))
        else $error("last grid beat is not the final cell");

    // Input reopens only after the final result beat of a solve has been loaded.
    a_reopen_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && m_tvalid) |-> m_tlast)
        else $error("input open while a dump is still in progress");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the grid maze depth-first solver, with a built-in predictor.
`timescale 1ns / 1ps

module testbench;
    import gmdfs_pkg::*;

    localparam int SIDE         = 8;
    localparam int CELLS        = SIDE * SIDE;
    localparam int LIMIT_CYCLES = 1_000_000;

    // One expected result beat, in the order the fields appear in m_tdata.
    typedef struct packed {
        logic               solved;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [CODE_W-1:0]  code;
        logic               last;
    } cell_beat_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // Predictor state: the maze as the block should hold it.
    logic [CODE_W-1:0] maze_grid [CELLS];
    cell_beat_t        pending_cells [$];

    int idle_pct      = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;
    int error_count   = 0;
    int counted_beats = 0;
    int solves_sent   = 0;
    int solves_found  = 0;
    int checked_beats = 0;

    grid_maze_depth_first_solver_unit #(
        .GRID_SIDE(SIDE)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    // The receiver drops m_tready at random, at the rate of the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // A hung block must not hang the run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d result beats still due",
                     cycle_count, pending_cells.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Neighbor of a cell in one search direction; false when it leaves the grid.
    function automatic bit step_cell(input int pos, input int dir, output int nb);
        int r;
        int c;
        r = pos / SIDE;
        c = pos % SIDE;
        nb = pos;
        case (dir)
            DIR_RIGHT: begin
                if (c + 1 >= SIDE) return 1'b0;
                c++;
            end
            DIR_DOWN: begin
                if (r + 1 >= SIDE) return 1'b0;
                r++;
            end
            DIR_UP: begin
                if (r == 0) return 1'b0;
                r--;
            end
            default: begin
                if (c == 0) return 1'b0;
                c--;
            end
        endcase
        nb = r * SIDE + c;
        return 1'b1;
    endfunction

    // Depth-first walk from one cell, marking the grid as the block does.
    // Returns true when a finish cell is reached.
    function automatic bit search_from(input int origin);
        logic [7:0] trail [CELLS];
        int         depth;
        int         pos;
        int         dir;
        int         nb;
        bit         moved;
        pos   = origin;
        dir   = 0;
        depth = 0;
        if (maze_grid[pos] == CODE_FINISH) return 1'b1;
        if (maze_grid[pos] == CODE_WALL || maze_grid[pos] == CODE_PATH) return 1'b0;
        maze_grid[pos] = CODE_PATH;
        while (1) begin
            moved = 1'b0;
            while (dir < 4 && !moved) begin
                if (step_cell(pos, dir, nb)) begin
                    if (maze_grid[nb] == CODE_FINISH) return 1'b1;
                    if (maze_grid[nb] != CODE_WALL && maze_grid[nb] != CODE_PATH) begin
                        maze_grid[nb] = CODE_PATH;
                        trail[depth]  = {dir[1:0], pos[5:0]};
                        depth++;
                        pos   = nb;
                        dir   = 0;
                        moved = 1'b1;
                    end
                end
                if (!moved) dir++;
            end
            if (!moved) begin
                // Dead end: give the cell back and resume at the parent.
                maze_grid[pos] = CODE_OPEN;
                if (depth == 0) return 1'b0;
                depth--;
                pos = int'(trail[depth][5:0]);
                dir = int'(trail[depth][7:6]) + 1;
            end
        end
        return 1'b0;
    endfunction

    // Expected beats of one solve command.
    function automatic void predict_solve();
        cell_beat_t beat;
        int         origin;
        origin = 0;
        for (int i = 0; i < CELLS; i++) begin
            if (maze_grid[i] == CODE_START) origin = i;
        end
        solves_sent++;
        if (!search_from(origin)) begin
            beat = '0;
            beat.last = 1'b1;
            pending_cells.push_back(beat);
        end else begin
            solves_found++;
            maze_grid[origin] = CODE_START;
            for (int i = 0; i < CELLS; i++) begin
                beat.solved = 1'b1;
                beat.row    = COORD_W'(i / SIDE);
                beat.col    = COORD_W'(i % SIDE);
                beat.code   = maze_grid[i];
                beat.last   = (i == CELLS - 1);
                pending_cells.push_back(beat);
            end
        end
    endfunction

    // Offer one input beat, wait for it to be taken, then update the prediction.
    // s_tvalid is left high so that back-to-back beats need no second assignment.
    task automatic send_beat(input logic cmd, input logic [2:0] row, input logic [2:0] col,
                             input logic [2:0] code);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, code, col, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == CMD_SOLVE) begin
            predict_solve();
            counted_beats++;
        end else if (code <= CODE_PATH && row < SIDE && col < SIDE) begin
            maze_grid[row * SIDE + col] = code;
            counted_beats++;
        end
    endtask

    task automatic write_cell(input int row, input int col, input logic [2:0] code);
        send_beat(CMD_WRITE, row[2:0], col[2:0], code);
    endtask

    // The data fields of a solve beat carry no meaning, so they are randomized.
    task automatic solve_maze();
        send_beat(CMD_SOLVE, 3'($urandom), 3'($urandom), 3'($urandom));
    endtask

    // Stop offering beats and wait until every predicted result has come out.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
    endtask

    // Result checker: every accepted output beat is held against the oldest expectation.
    function automatic void report_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endfunction

    always @(posedge aclk) begin : check_results
        cell_beat_t got;
        cell_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.solved = m_tdata[0];
            got.row    = m_tdata[3:1];
            got.col    = m_tdata[6:4];
            got.code   = m_tdata[9:7];
            got.last   = m_tlast;
            checked_beats++;
            if (pending_cells.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, got);
            end else begin
                want = pending_cells.pop_front();
                if (got.solved !== want.solved)
                    report_field("solved", 8'(want.solved), 8'(got.solved));
                if (got.row !== want.row)
                    report_field("out_row", 8'(want.row), 8'(got.row));
                if (got.col !== want.col)
                    report_field("out_col", 8'(want.col), 8'(got.col));
                if (got.code !== want.code)
                    report_field("out_code", 8'(want.code), 8'(got.code));
                if (got.last !== want.last)
                    report_field("last", 8'(want.last), 8'(got.last));
            end
        end
    end

    // An empty grid is all wall, so the default origin at row 0, column 0 fails at once.
    task automatic test_empty_grid_solve();
        solve_maze();
        wait_for_results();
    endtask

    // Without any start cell the origin is row 0, column 0; a finish there solves
    // immediately and turns into a start cell.
    task automatic test_start_on_finish();
        write_cell(0, 0, CODE_FINISH);
        solve_maze();
        wait_for_results();
    endtask

    // A two-step corridor to a finish.
    task automatic test_short_corridor();
        write_cell(0, 1, CODE_OPEN);
        write_cell(0, 2, CODE_FINISH);
        solve_maze();
        wait_for_results();
    endtask

    // Codes above path are dropped; the next solve is blocked by the old path mark
    // and leaves the start cell open.
    task automatic test_ignored_writes();
        write_cell(0, 1, 3'd5);
        write_cell(3, 4, 3'd6);
        write_cell(7, 7, 3'd7);
        solve_maze();
        wait_for_results();
    endtask

    // The last start in row-major order is used; its search backtracks out of a
    // dead end and fails.
    task automatic test_last_start_dead_end();
        write_cell(0, 0, CODE_START);
        write_cell(7, 7, CODE_START);
        write_cell(6, 7, CODE_OPEN);
        solve_maze();
        wait_for_results();
    endtask

    // With no start cell and a path mark at the origin the search fails at once.
    task automatic test_blocked_start();
        write_cell(0, 0, CODE_PATH);
        solve_maze();
        write_cell(0, 0, CODE_OPEN);
        write_cell(1, 0, CODE_FINISH);
        solve_maze();
        wait_for_results();
    endtask

    // Random mazes: stale marks are cleaned up, a random corridor is carved from
    // a new start towards a finish, a little noise is added, then a solve follows.
    task automatic test_random_mazes(input int quota, input int idle, input int stall);
        int target;
        int r;
        int c;
        int p;
        int first;
        int left;
        idle_pct  = idle;
        stall_pct = stall;
        target    = counted_beats + quota;
        while (counted_beats < target) begin
            if ($urandom_range(9) != 0) begin
                left  = $urandom_range(1, 5);
                first = $urandom_range(CELLS - 1);
                for (int k = 0; k < CELLS && left > 0; k++) begin
                    p = (first + k) % CELLS;
                    if (maze_grid[p] == CODE_PATH || maze_grid[p] == CODE_START ||
                        (maze_grid[p] == CODE_FINISH && $urandom_range(1))) begin
                        write_cell(p / SIDE, p % SIDE, CODE_OPEN);
                        left--;
                    end
                end
                r = $urandom_range(SIDE - 1);
                c = $urandom_range(SIDE - 1);
                write_cell(r, c, CODE_START);
                repeat ($urandom_range(1, 7)) begin
                    case ($urandom_range(3))
                        DIR_RIGHT: if (c < SIDE - 1) c++;
                        DIR_DOWN:  if (r < SIDE - 1) r++;
                        DIR_UP:    if (r > 0) r--;
                        default:   if (c > 0) c--;
                    endcase
                    write_cell(r, c, ($urandom_range(9) == 0) ? CODE_WALL : CODE_OPEN);
                end
                if ($urandom_range(4) != 0) write_cell(r, c, CODE_FINISH);
                repeat ($urandom_range(3)) begin
                    write_cell($urandom_range(SIDE - 1), $urandom_range(SIDE - 1),
                               $urandom_range(1) ? CODE_WALL : 3'($urandom_range(7)));
                end
            end
            solve_maze();
        end
        wait_for_results();
    endtask

    initial begin
        for (int i = 0; i < CELLS; i++) maze_grid[i] = CODE_WALL;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_grid_solve();
        test_start_on_finish();
        test_short_corridor();
        test_ignored_writes();
        test_last_start_dead_end();
        test_blocked_start();

        test_random_mazes(88, 0, 0);
        test_random_mazes(88, 80, 0);
        test_random_mazes(88, 0, 80);
        test_random_mazes(88, 32, 32);

        // The block is idle once the last result beat is out; a short wait catches
        // any stray beats.
        repeat (100) @(posedge aclk);
        if (pending_cells.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected result beats never arrived", $time,
                     pending_cells.size());
        end

        $display("Covered %0d input beats with %0d solves, %0d of them reaching a finish.",
                 counted_beats, solves_sent, solves_found);
        $display("Checked %0d result beats under four idle and stall patterns.",
                 checked_beats);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
